@@ src/hbmq_pkg.sv @@
// package with sizes, operation codes and the highest-set-bit encoder of the bitmap queue
`timescale 1ns / 1ps

package hbmq_pkg;

  localparam int unsigned RANK_BITS  = 12;
  localparam int unsigned WORD_LOG   = 6;
  localparam int unsigned WORD_BITS  = 1 << WORD_LOG;
  localparam int unsigned IDX_BITS   = RANK_BITS - WORD_LOG;
  localparam int unsigned LEAF_WORDS = 1 << IDX_BITS;

  typedef logic [RANK_BITS-1:0]  rank_t;
  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [WORD_LOG-1:0]   bitpos_t;
  typedef logic [LEAF_WORDS-1:0] summary_t;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // binary search for the highest set bit, one halving per step
  function automatic bitpos_t high_bit(word_t w);
    word_t   v;
    bitpos_t p;
    v = w;
    p = '0;
    for (int i = WORD_LOG - 1; i >= 0; i--) begin
      if ((v >> (1 << i)) != '0) begin
        p[i] = 1'b1;
        v    = v >> (1 << i);
      end
    end
    return p;
  endfunction

endpackage

@@ src/hierarchical_bitmap_max_queue.sv @@
// top level of the bitmap max queue: sequencer, leaf memory, summary word and result register
`timescale 1ns / 1ps

// Keeps a set of 12-bit ranks as a 64 x 64 leaf bitmap memory with a 64-bit summary word.
// Input channel (in_valid_i/in_ready_o) takes one word: func_i = 0 inserts rank_i,
// func_i = 1 removes the current maximum. Every input word yields one output word
// (out_valid_o/out_ready_i): top_rank_o, is_empty_o and fault_o after the operation.
// in_ready_o is high only while the sequencer is idle. States from acceptance to
// out_valid_o: insert ST_INS, ST_FIN; remove from an empty set ST_FIN; remove that leaves
// its leaf word non-empty or empties the whole set ST_RM_CLR, ST_RM_SCAN, ST_FIN; remove
// that moves on to a lower leaf word adds ST_RM_LEAF. The next word is taken the cycle
// after the result is loaded. The pace is set by the single leaf memory port with its
// registered read data and by the one shared highest-bit encoder, used once per level.
// Reset empties the set at once: the summary word doubles as the valid bits of the
// leaf words, so the memory needs no clearing pass and no item is held off.
// When the receiver stalls, the result waits in the output register; the block still
// accepts and works on the next word and holds its result in the final step until
// the output register is free.
module hierarchical_bitmap_max_queue
  import hbmq_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 func_i,
  input  logic [RANK_BITS-1:0] rank_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [RANK_BITS-1:0] top_rank_o,
  output logic                 is_empty_o,
  output logic                 fault_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_RM_CLR,
    ST_RM_SCAN,
    ST_RM_LEAF,
    ST_FIN
  } state_e;

  state_e   state_q, state_d;
  summary_t summary_q, summary_d;
  rank_t    top_q, top_d;
  logic     empty_q, empty_d;
  logic     fault_q, fault_d;
  rank_t    rank_q, rank_d;
  idx_t     idx_q, idx_d;
  word_t    word_q, word_d;
  logic     out_valid_q, out_valid_d;
  rank_t    out_top_q, out_top_d;
  logic     out_empty_q, out_empty_d;
  logic     out_fault_q, out_fault_d;

  // leaf memory
  word_t    leaf_mem_q [LEAF_WORDS];
  word_t    rd_data_q;
  idx_t     mem_raddr;
  idx_t     mem_waddr;
  word_t    mem_wdata;
  logic     mem_we;

  logic     accept;
  bitpos_t  enc_in_sel;
  word_t    enc_in;
  bitpos_t  enc_out;
  word_t    old_word;
  word_t    cleared;

  assign accept = in_valid_i && in_ready_o;

  // shared highest-bit encoder
  always_comb begin
    enc_in = word_q;
    unique case (state_q)
      ST_RM_SCAN: enc_in = (word_q != '0) ? word_q : word_t'(summary_q);
      ST_RM_LEAF: enc_in = rd_data_q;
      default:    enc_in = word_q;
    endcase
  end

  assign enc_out    = high_bit(enc_in);
  assign enc_in_sel = enc_out;

  assign old_word = summary_q[idx_q] ? rd_data_q : '0;
  assign cleared  = rd_data_q & ~(word_t'(1) << top_q[WORD_LOG-1:0]);

  always_comb begin
    state_d     = state_q;
    summary_d   = summary_q;
    top_d       = top_q;
    empty_d     = empty_q;
    fault_d     = fault_q;
    rank_d      = rank_q;
    idx_d       = idx_q;
    word_d      = word_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_top_d   = out_top_q;
    out_empty_d = out_empty_q;
    out_fault_d = out_fault_q;
    mem_raddr   = idx_q;
    mem_waddr   = idx_q;
    mem_wdata   = cleared;
    mem_we      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (func_i == FUNC_REMOVE) begin
          mem_raddr = top_q[RANK_BITS-1:WORD_LOG];
        end else begin
          mem_raddr = rank_i[RANK_BITS-1:WORD_LOG];
        end
        if (accept) begin
          rank_d  = rank_i;
          fault_d = 1'b0;
          if (func_i == FUNC_INSERT) begin
            idx_d   = rank_i[RANK_BITS-1:WORD_LOG];
            state_d = ST_INS;
          end else if (empty_q) begin
            fault_d = 1'b1;
            state_d = ST_FIN;
          end else begin
            idx_d   = top_q[RANK_BITS-1:WORD_LOG];
            state_d = ST_RM_CLR;
          end
        end
      end
      ST_INS: begin
        mem_we           = 1'b1;
        mem_wdata        = old_word | (word_t'(1) << rank_q[WORD_LOG-1:0]);
        summary_d[idx_q] = 1'b1;
        if (empty_q || rank_q > top_q) begin
          top_d = rank_q;
        end
        empty_d = 1'b0;
        state_d = ST_FIN;
      end
      ST_RM_CLR: begin
        mem_we    = 1'b1;
        mem_wdata = cleared;
        word_d    = cleared;
        if (cleared == '0) begin
          summary_d[idx_q] = 1'b0;
        end
        state_d = ST_RM_SCAN;
      end
      ST_RM_SCAN: begin
        if (word_q != '0) begin
          top_d   = {idx_q, enc_in_sel};
          state_d = ST_FIN;
        end else if (summary_q == '0) begin
          top_d   = '0;
          empty_d = 1'b1;
          state_d = ST_FIN;
        end else begin
          idx_d     = idx_t'(enc_in_sel);
          mem_raddr = idx_t'(enc_in_sel);
          state_d   = ST_RM_LEAF;
        end
      end
      ST_RM_LEAF: begin
        top_d   = {idx_q, enc_in_sel};
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_top_d   = empty_q ? '0 : top_q;
          out_empty_d = empty_q;
          out_fault_d = fault_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      summary_q   <= '0;
      top_q       <= '0;
      empty_q     <= 1'b1;
      fault_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      summary_q   <= summary_d;
      top_q       <= top_d;
      empty_q     <= empty_d;
      fault_q     <= fault_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rank_q      <= rank_d;
    idx_q       <= idx_d;
    word_q      <= word_d;
    out_top_q   <= out_top_d;
    out_empty_q <= out_empty_d;
    out_fault_q <= out_fault_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      leaf_mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= leaf_mem_q[mem_raddr];
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign top_rank_o  = out_top_q;
  assign is_empty_o  = out_empty_q;
  assign fault_o     = out_fault_q;

`ifndef SYNTHESIS
  a_empty_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q |-> (top_q == '0 && summary_q == '0))
    else $error("empty set with stale top rank or summary bits");

  a_top_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_q && state_q != ST_RM_SCAN && state_q != ST_RM_LEAF)
      |-> summary_q[top_q[RANK_BITS-1:WORD_LOG]])
    else $error("top rank lies in a leaf word marked empty");

  a_fault_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fault_o) |-> (is_empty_o && top_rank_o == '0))
    else $error("fault reported on a non-empty set");

  a_clear_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RM_CLR) |=> (state_q == ST_RM_SCAN))
    else $error("remove sequence skipped the scan step");
`endif

endmodule

@@ sim/hbmq_max_tracker.sv @@
// checker for the bitmap max queue: tracks the rank set, predicts each result word and compares
`timescale 1ns / 1ps

module hbmq_max_tracker
  import hbmq_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_ready_i,
  input  logic  func_i,
  input  rank_t rank_i,
  input  logic  out_valid_i,
  input  logic  out_ready_i,
  input  rank_t top_rank_i,
  input  logic  is_empty_i,
  input  logic  fault_i,
  output int    errors_o,
  output int    pending_o,
  output int    faults_o,
  output int    drains_o
);

  typedef struct packed {
    rank_t top_rank;
    logic  is_empty;
    logic  fault;
  } queue_result_t;

  word_t    leaf_bits [LEAF_WORDS];
  summary_t summary_bits;
  rank_t    top_q;
  logic     set_empty;

  queue_result_t top_rank_due [$];

  int mismatches;
  int waiting;
  int fault_count;
  int drain_count;

  assign errors_o  = mismatches;
  assign pending_o = waiting;
  assign faults_o  = fault_count;
  assign drains_o  = drain_count;

  function automatic bitpos_t msb_index(word_t w);
    bitpos_t p;
    p = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (w[i]) begin
        p = bitpos_t'(i);
      end
    end
    return p;
  endfunction

  // applies one operation to the tracked set and returns the result word it should give
  function automatic queue_result_t apply_word(logic f, rank_t r);
    queue_result_t res;
    idx_t          wi;
    bitpos_t       bp;
    res.fault = 1'b0;
    if (f == FUNC_INSERT) begin
      wi = r[RANK_BITS-1:WORD_LOG];
      bp = r[WORD_LOG-1:0];
      leaf_bits[wi][bp] = 1'b1;
      summary_bits[wi]  = 1'b1;
      if (set_empty || r > top_q) begin
        top_q = r;
      end
      set_empty = 1'b0;
    end else if (set_empty) begin
      res.fault = 1'b1;
    end else begin
      wi = top_q[RANK_BITS-1:WORD_LOG];
      bp = top_q[WORD_LOG-1:0];
      leaf_bits[wi][bp] = 1'b0;
      if (leaf_bits[wi] != '0) begin
        top_q = {wi, msb_index(leaf_bits[wi])};
      end else begin
        summary_bits[wi] = 1'b0;
        if (summary_bits != '0) begin
          wi    = idx_t'(msb_index(word_t'(summary_bits)));
          top_q = {wi, msb_index(leaf_bits[wi])};
        end else begin
          set_empty = 1'b1;
          top_q     = '0;
        end
      end
    end
    res.top_rank = set_empty ? '0 : top_q;
    res.is_empty = set_empty;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    queue_result_t due;
    queue_result_t got;
    if (!rst_ni) begin
      for (int w = 0; w < LEAF_WORDS; w++) begin
        leaf_bits[w] = '0;
      end
      summary_bits = '0;
      top_q        = '0;
      set_empty    = 1'b1;
      top_rank_due.delete();
      mismatches   = 0;
      waiting      = 0;
      fault_count  = 0;
      drain_count  = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (top_rank_due.size() == 0) begin
          mismatches++;
          $error("result word with nothing expected: top_rank %0d is_empty %0b fault %0b",
                 top_rank_i, is_empty_i, fault_i);
        end else begin
          due = top_rank_due.pop_front();
          if (top_rank_i !== due.top_rank) begin
            mismatches++;
            $error("top_rank mismatch: expected %0d, actual %0d", due.top_rank, top_rank_i);
          end
          if (is_empty_i !== due.is_empty) begin
            mismatches++;
            $error("is_empty mismatch: expected %0b, actual %0b", due.is_empty, is_empty_i);
          end
          if (fault_i !== due.fault) begin
            mismatches++;
            $error("fault mismatch: expected %0b, actual %0b", due.fault, fault_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        got = apply_word(func_i, rank_i);
        top_rank_due.push_back(got);
        if (got.fault) begin
          fault_count++;
        end else if (func_i == FUNC_REMOVE && got.is_empty) begin
          drain_count++;
        end
      end
      waiting = top_rank_due.size();
    end
  end

endmodule

@@ sim/tb.sv @@
// testbench top for the bitmap max queue: clock, reset, word stimulus, result stalls and verdict
`timescale 1ns / 1ps

module tb;
  import hbmq_pkg::*;

  localparam int RANDOM_WORDS = 1150;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 400000;

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_ready_o;
  logic  func_i;
  rank_t rank_i;
  logic  out_valid_o;
  logic  out_ready_i;
  rank_t top_rank_o;
  logic  is_empty_o;
  logic  fault_o;

  int tracker_errors;
  int tracker_pending;
  int tracker_faults;
  int tracker_drains;

  logic hold_req;
  logic no_idle;
  int   cycles;
  int   inserts_sent;
  int   removes_sent;

  hierarchical_bitmap_max_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .rank_i      (rank_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .top_rank_o  (top_rank_o),
    .is_empty_o  (is_empty_o),
    .fault_o     (fault_o)
  );

  hbmq_max_tracker u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .func_i      (func_i),
    .rank_i      (rank_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .top_rank_i  (top_rank_o),
    .is_empty_i  (is_empty_o),
    .fault_i     (fault_o),
    .errors_o    (tracker_errors),
    .pending_o   (tracker_pending),
    .faults_o    (tracker_faults),
    .drains_o    (tracker_drains)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (no_idle || pick < 60) begin
      return 0;
    end else if (pick < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic rank_t pick_rank(int mode, idx_t base);
    idx_t w;
    int   pick;
    case (mode)
      1: begin
        w = base + idx_t'($urandom_range(0, 2));
        return {w, bitpos_t'($urandom)};
      end
      2: begin
        w    = idx_t'($urandom);
        pick = $urandom_range(0, 3);
        case (pick)
          0: return '0;
          1: return '1;
          2: return {w, {WORD_LOG{1'b1}}};
          default: return {w, {WORD_LOG{1'b0}}};
        endcase
      end
      default: return rank_t'($urandom);
    endcase
  endfunction

  // offers one word and returns at the edge that takes it
  task automatic send_word(logic f, rank_t r, int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    rank_i     <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (f == FUNC_INSERT) begin
      inserts_sent++;
    end else begin
      removes_sent++;
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker_pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin : rx
    int pick;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (no_idle) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          out_ready_i <= 1'b1;
          repeat ($urandom_range(1, 12)) @(posedge clk_i);
        end else if (pick < 95) begin
          out_ready_i <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk_i);
        end else begin
          out_ready_i <= 1'b0;
          repeat ($urandom_range(15, 40)) @(posedge clk_i);
        end
      end
    end
  end

  initial begin : stim
    int    sent;
    int    seg;
    int    op_mode;
    int    rank_mode;
    int    ins_pct;
    int    seg_len;
    idx_t  base;
    logic  f;
    logic  ops [$];
    rank_t ranks [$];

    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    func_i       = FUNC_INSERT;
    rank_i       = '0;
    hold_req     = 1'b0;
    no_idle      = 1'b0;
    inserts_sent = 0;
    removes_sent = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // remove on empty, single rank, duplicates, leaf words emptied in turn
    ops   = '{FUNC_REMOVE, FUNC_INSERT, FUNC_REMOVE, FUNC_INSERT, FUNC_INSERT, FUNC_REMOVE,
              FUNC_INSERT, FUNC_INSERT, FUNC_INSERT, FUNC_INSERT, FUNC_INSERT, FUNC_INSERT,
              FUNC_INSERT, FUNC_INSERT, FUNC_REMOVE, FUNC_REMOVE, FUNC_REMOVE, FUNC_REMOVE,
              FUNC_REMOVE, FUNC_REMOVE, FUNC_REMOVE, FUNC_REMOVE, FUNC_REMOVE};
    ranks = '{12'd0, 12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd0,
              12'd100, 12'd3000, 12'd64, 12'd127, 12'd2730, 12'd1365,
              12'd63, 12'd2047, 12'd4095, 12'd0, 12'd4095, 12'd0,
              12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095};
    foreach (ops[i]) begin
      send_word(ops[i], ranks[i], gap_len());
    end
    wait_drained();

    sent = 0;
    seg  = 0;
    while (sent < RANDOM_WORDS) begin
      op_mode   = $urandom_range(0, 2);
      rank_mode = $urandom_range(0, 2);
      base      = idx_t'($urandom);
      seg_len   = $urandom_range(20, 60);
      ins_pct   = (op_mode == 0) ? 80 : (op_mode == 1) ? 25 : 52;
      no_idle   = (seg % 4 == 3);
      if (seg == 5) begin
        hold_req = 1'b1;
      end
      for (int i = 0; i < seg_len; i++) begin
        f = ($urandom_range(0, 99) < ins_pct) ? FUNC_INSERT : FUNC_REMOVE;
        send_word(f, pick_rank(rank_mode, base), hold_req ? 0 : gap_len());
        sent++;
      end
      if (seg == 9) begin
        wait_drained();
      end
      seg++;
    end
    no_idle = 1'b0;
    wait_drained();

    $display("sent %0d inserts and %0d removes over %0d segments", inserts_sent,
             removes_sent, seg);
    $display("set drained to empty %0d times, %0d removes hit an empty set", tracker_drains,
             tracker_faults);
    if (tracker_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
